### design/svc_pkg.sv
// ---------------------------------------------------------------------------
// svc_pkg: shared types and constants for the signed varint codec
// Request and result payloads, controller/datapath command and status
// bundles, and the byte format constants.
// ---------------------------------------------------------------------------
package svc_pkg;

  // request and result codes
  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_WORD  = 1'b1;

  // byte format
  localparam logic [7:0] CONT_FLAG = 8'h80;
  localparam logic [7:0] SIGN_FLAG = 8'h40;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] word_in;
    logic        [7:0]  byte_in;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic        [7:0]  byte_out;
    logic               last;
    logic signed [31:0] word_out;
    logic               error;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic enc_start;
    logic enc_emit;
    logic dec_take;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic enc_last;
  } sts_t;

endpackage

### design/svc_ctrl.sv
// ---------------------------------------------------------------------------
// svc_ctrl: request sequencer
// Accepts requests, starts an encode or hands a byte to the decoder, and
// paces the encoder one byte per cycle, while the output register is free, into it.
// ---------------------------------------------------------------------------
module svc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          req_type,
  output logic          in_ready,
  input  svc_pkg::sts_t sts,
  output svc_pkg::cmd_t cmd
);
  import svc_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_ENC  = 1'b1;

  logic state_r;
  logic state_nxt;
  logic take;

  assign in_ready = (state_r == S_IDLE) && sts.out_free;
  assign take     = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          if (req_type == REQ_ENCODE) begin
            cmd.enc_start = 1'b1;
            state_nxt     = S_ENC;
          end else begin
            cmd.dec_take = 1'b1;
          end
        end
      end
      S_ENC: begin
        // one byte per cycle whenever the output slot is free
        if (sts.out_free) begin
          cmd.enc_emit = 1'b1;
          if (sts.enc_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/svc_datapath.sv
// ---------------------------------------------------------------------------
// svc_datapath: encoder shift register, decoder accumulator, output register
// Holds the magnitude being encoded, the decoder's gathered bits and count,
// and the single result register toward the output channel.
// ---------------------------------------------------------------------------
module svc_datapath #(
  parameter int WORD_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  svc_pkg::in_t  in_data,
  input  svc_pkg::cmd_t cmd,
  output svc_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output svc_pkg::out_t out_data
);
  import svc_pkg::*;

  localparam int IN_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int SC_W    = $clog2(WORD_BITS + 7);

  // encoder
  logic [IN_BITS-1:0] mag_r, mag_nxt, load_v, load_mag;
  logic               sign_r;
  logic               pend_r, pend_nxt;
  logic [7:0]         enc_byte;
  logic               enc_last;

  // decoder
  logic [WORD_BITS-1:0] acc_r;
  logic [SC_W-1:0]      sc_r;
  logic [WORD_BITS-1:0] grp7, grp6, acc7, acc6, dec_word;
  logic [31:0]          word32;
  logic                 dec_cont, dec_err, dec_result;

  // output register
  out_t out_r;
  logic out_valid_r;
  logic out_free;

  assign out_free     = !out_valid_r || out_ready;
  assign sts.out_free = out_free;
  assign sts.enc_last = enc_last;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

  // unsigned magnitude so the most negative word survives
  assign load_v   = in_data.word_in[IN_BITS-1:0];
  assign load_mag = load_v[IN_BITS-1] ? (~load_v + 1'b1) : load_v;

  always_comb begin
    enc_byte = '0;
    enc_last = 1'b0;
    mag_nxt  = mag_r;
    pend_nxt = pend_r;
    if (pend_r) begin
      // trailing sign-only byte after a 64..127 remainder
      enc_byte = sign_r ? SIGN_FLAG : 8'h00;
      enc_last = 1'b1;
      pend_nxt = 1'b0;
    end else if (|mag_r[IN_BITS-1:7]) begin
      enc_byte = CONT_FLAG | {1'b0, mag_r[6:0]};
      mag_nxt  = mag_r >> 7;
    end else if (mag_r[6]) begin
      enc_byte = CONT_FLAG | {1'b0, mag_r[6:0]};
      pend_nxt = 1'b1;
    end else begin
      enc_byte = (sign_r ? SIGN_FLAG : 8'h00) | {2'b00, mag_r[5:0]};
      enc_last = 1'b1;
    end
  end

  // groups past the word width shift out to zero
  assign grp7     = WORD_BITS'(in_data.byte_in[6:0]) << sc_r;
  assign grp6     = WORD_BITS'(in_data.byte_in[5:0]) << sc_r;
  assign acc7     = acc_r | grp7;
  assign acc6     = acc_r | grp6;
  assign dec_word = in_data.byte_in[6] ? (~acc6 + 1'b1) : acc6;
  assign word32   = 32'(dec_word);
  assign dec_cont = in_data.byte_in[7];
  assign dec_err  = dec_cont && (sc_r >= SC_W'(WORD_BITS));
  assign dec_result = !dec_cont || dec_err;

  always_ff @(posedge clk) begin
    if (cmd.enc_start) begin
      mag_r  <= load_mag;
      sign_r <= load_v[IN_BITS-1];
    end else if (cmd.enc_emit) begin
      mag_r <= mag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (cmd.enc_start) begin
      pend_r <= 1'b0;
    end else if (cmd.enc_emit) begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      sc_r  <= '0;
    end else if (cmd.dec_take) begin
      if (dec_cont && !dec_err) begin
        acc_r <= acc7;
        sc_r  <= sc_r + SC_W'(7);
      end else begin
        acc_r <= '0;
        sc_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enc_emit) begin
      out_r.kind     <= KIND_BYTE;
      out_r.byte_out <= enc_byte;
      out_r.last     <= enc_last;
      out_r.word_out <= '0;
      out_r.error    <= 1'b0;
    end else if (cmd.dec_take && dec_result) begin
      out_r.kind     <= KIND_WORD;
      out_r.byte_out <= '0;
      out_r.last     <= 1'b0;
      out_r.word_out <= dec_err ? 32'sd0 : $signed(word32);
      out_r.error    <= dec_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.enc_emit || (cmd.dec_take && dec_result)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

### design/signed_varint_codec.sv
// ---------------------------------------------------------------------------
// signed_varint_codec: sign-magnitude varint encoder and decoder
// Top level joining the request sequencer and the datapath.
// ---------------------------------------------------------------------------
// A decode request takes one byte; continuation bytes give no result, a
// final byte gives the signed word and an overlong run gives one error
// result. An encode request loads the magnitude register and then emits
// one to five bytes into the single output register, shifting the magnitude
// 7 bits per byte and pausing while that register is not free. Either
// request waits while that register holds a result that has not been
// taken.
module signed_varint_codec #(
  parameter int WORD_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  svc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output svc_pkg::out_t out_data
);
  import svc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  svc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .req_type (in_data.req_type),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  svc_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // an encode request holds off the next request
  a_enc_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.req_type == REQ_ENCODE) |=> !in_ready)
    else $error("request accepted while an encode was starting");

  // continuation flag and last marker agree on encoded bytes
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_BYTE) |-> (out_data.last == !out_data.byte_out[7]))
    else $error("encoded byte continuation flag disagrees with last");

  // an error result carries no word
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> (out_data.kind == KIND_WORD) && (out_data.word_out == 0))
    else $error("error result with nonzero word");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking testbench for signed_varint_codec
// Sends encode and decode requests with bursty valid and a stalling
// receiver, predicts every result in a scoreboard and checks each
// accepted result against the oldest prediction, field by field.
// ---------------------------------------------------------------------------

class varint_scoreboard;

  localparam logic [63:0] WORD_MASK = 64'h0000_0000_FFFF_FFFF;
  localparam int unsigned WORD_BITS = 32;

  // decoder state as the block should hold it
  logic [63:0]   acc_bits;
  int unsigned   acc_shift;

  svc_pkg::out_t pending_results[$];
  int            mismatches;
  int            results_checked;
  int            encodes_seen;
  int            decode_bytes_seen;
  int            words_decoded;
  int            overlong_runs;

  function new();
    acc_bits          = '0;
    acc_shift         = 0;
    mismatches        = 0;
    results_checked   = 0;
    encodes_seen      = 0;
    decode_bytes_seen = 0;
    words_decoded     = 0;
    overlong_runs     = 0;
  endfunction

  // byte groups of one encoded word, returns how many
  function int encode_groups(input logic [31:0] word, output logic [7:0] grp[5]);
    logic [32:0] mag;
    logic [7:0]  sgn;
    int          n;
    mag = word[31] ? ({1'b0, ~word} + 33'd1) : {1'b0, word};
    sgn = word[31] ? svc_pkg::SIGN_FLAG : 8'h00;
    n   = 0;
    while (mag >= 33'd128 && n < 4) begin
      grp[n] = svc_pkg::CONT_FLAG | {1'b0, mag[6:0]};
      n++;
      mag = mag >> 7;
    end
    // remainder too wide for six bits takes one more group
    if (mag >= 33'd64) begin
      grp[n] = svc_pkg::CONT_FLAG | {1'b0, mag[6:0]};
      n++;
      grp[n] = sgn;
      n++;
    end else begin
      grp[n] = sgn | {2'b00, mag[5:0]};
      n++;
    end
    return n;
  endfunction

  function void take_byte(input logic [7:0] b);
    svc_pkg::out_t res;
    logic [63:0]   word;
    res      = '0;
    res.kind = svc_pkg::KIND_WORD;
    if ((b & svc_pkg::CONT_FLAG) != 0) begin
      if (acc_shift >= WORD_BITS) begin
        acc_bits  = '0;
        acc_shift = 0;
        res.error = 1'b1;
        pending_results.push_back(res);
        overlong_runs++;
      end else begin
        acc_bits  = (acc_bits | ({57'd0, b[6:0]} << acc_shift)) & WORD_MASK;
        acc_shift = acc_shift + 7;
      end
    end else begin
      if (acc_shift < 64)
        acc_bits = (acc_bits | ({58'd0, b[5:0]} << acc_shift)) & WORD_MASK;
      word = acc_bits;
      if ((b & svc_pkg::SIGN_FLAG) != 0)
        word = (64'd0 - word) & WORD_MASK;
      acc_bits     = '0;
      acc_shift    = 0;
      res.word_out = word[31:0];
      pending_results.push_back(res);
      words_decoded++;
    end
  endfunction

  function void note_request(input svc_pkg::in_t req);
    logic [7:0]    grp[5];
    svc_pkg::out_t res;
    int            n;
    if (req.req_type == svc_pkg::REQ_ENCODE) begin
      n = encode_groups(req.word_in, grp);
      for (int i = 0; i < n; i++) begin
        res          = '0;
        res.kind     = svc_pkg::KIND_BYTE;
        res.byte_out = grp[i];
        res.last     = (i == n - 1);
        pending_results.push_back(res);
      end
      encodes_seen++;
    end else begin
      take_byte(req.byte_in);
      decode_bytes_seen++;
    end
  endfunction

  function void compare_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(input svc_pkg::out_t got);
    svc_pkg::out_t want;
    if (pending_results.size() == 0) begin
      $display("%0t unexpected result: expected none actual %h", $time, got);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    compare_field("kind", 32'(want.kind), 32'(got.kind));
    compare_field("byte_out", 32'(want.byte_out), 32'(got.byte_out));
    compare_field("last", 32'(want.last), 32'(got.last));
    compare_field("word_out", want.word_out, got.word_out);
    compare_field("error", 32'(want.error), 32'(got.error));
  endfunction

endclass

module tb_top;

  import svc_pkg::*;

  localparam int RANDOM_ITEMS  = 145;
  localparam int LONG_HOLD     = 80;
  localparam int DRAIN_CYCLES  = 20;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  varint_scoreboard sb;
  in_t              request_plan[$];
  bit               long_hold_done;
  int               rx_cycle;

  signed_varint_codec u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // accepted requests and results, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_request(in_data);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_data);
  end

  function automatic in_t encode_req(input logic [31:0] word);
    in_t r;
    r.req_type = REQ_ENCODE;
    r.word_in  = word;
    r.byte_in  = 8'($urandom);
    return r;
  endfunction

  function automatic in_t decode_req(input logic [7:0] b);
    in_t r;
    r.req_type = REQ_DECODE;
    r.word_in  = $urandom;
    r.byte_in  = b;
    return r;
  endfunction

  // magnitudes spread over all group counts, extremes now and then
  function automatic logic [31:0] random_word();
    logic [31:0] v;
    int          bits;
    bits = $urandom_range(0, 32);
    v    = $urandom;
    if ($urandom_range(0, 15) == 0)
      return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (bits < 32)
      v = v & ((32'd1 << bits) - 32'd1);
    if ($urandom_range(0, 1) == 1)
      v = -v;
    return v;
  endfunction

  function automatic void plan_decode_of(input logic [31:0] word);
    logic [7:0] grp[5];
    int         n;
    n = sb.encode_groups(word, grp);
    for (int i = 0; i < n; i++)
      request_plan.push_back(decode_req(grp[i]));
  endfunction

  // bursts of random length with random gaps; called at a falling edge
  task automatic drive_plan();
    int burst_left;
    int gap;
    burst_left = $urandom_range(1, 12);
    while (request_plan.size() > 0) begin
      in_valid = 1'b1;
      in_data  = request_plan.pop_front();
      @(posedge clk);
      while (!in_ready)
        @(posedge clk);
      @(negedge clk);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
    in_valid = 1'b0;
  endtask

  // receiver: stall pattern rotates through four modes, plus one long hold-off
  initial begin
    out_ready      = 1'b0;
    long_hold_done = 1'b0;
    rx_cycle       = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (!long_hold_done && sb != null && sb.results_checked >= 40) begin
        long_hold_done = 1'b1;
        out_ready      = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        case ((rx_cycle / 50) % 4)
          0: out_ready = 1'b1;
          1: out_ready = 1'($urandom_range(0, 1));
          2: out_ready = (rx_cycle % 4) == 0;
          default: out_ready = $urandom_range(0, 4) != 0;
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timed out with results still outstanding");
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int          kind_pick;
    int          run_len;
    logic [31:0] word;
    sb       = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: group boundaries, extremes and sign handling
    request_plan.push_back(encode_req(32'd0));
    request_plan.push_back(encode_req(32'd63));
    request_plan.push_back(encode_req(32'd64));
    request_plan.push_back(encode_req(32'd127));
    request_plan.push_back(encode_req(32'hFFFF_FFFF));
    request_plan.push_back(encode_req(32'hFFFF_FFC0));
    request_plan.push_back(encode_req(32'h7FFF_FFFF));
    request_plan.push_back(encode_req(32'h8000_0000));
    // most negative word as bytes
    plan_decode_of(32'h8000_0000);
    // full continuation run then a final byte whose bits fall off the top
    repeat (5) request_plan.push_back(decode_req(8'hFF));
    request_plan.push_back(decode_req(8'h7F));
    // one continuation too many
    repeat (6) request_plan.push_back(decode_req(CONT_FLAG));
    request_plan.push_back(decode_req(8'h00));
    drive_plan();

    // random: mostly well-formed words, some overlong runs and noise
    while (request_plan.size() < RANDOM_ITEMS) begin
      kind_pick = $urandom_range(0, 99);
      if (kind_pick < 40) begin
        request_plan.push_back(encode_req(random_word()));
      end else if (kind_pick < 75) begin
        plan_decode_of(random_word());
      end else if (kind_pick < 85) begin
        run_len = $urandom_range(5, 7);
        repeat (run_len) request_plan.push_back(decode_req(8'($urandom) | CONT_FLAG));
        if ($urandom_range(0, 1) == 1)
          request_plan.push_back(decode_req(8'($urandom) & ~CONT_FLAG));
      end else if (kind_pick < 95) begin
        run_len = $urandom_range(1, 3);
        repeat (run_len) request_plan.push_back(decode_req(8'($urandom)));
      end else begin
        // encode in the middle of a decode sequence
        word = random_word();
        request_plan.push_back(decode_req(8'($urandom) | CONT_FLAG));
        request_plan.push_back(encode_req(random_word()));
        plan_decode_of(word);
      end
    end
    drive_plan();

    while (sb.pending_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d encodes and %0d decode bytes, %0d results checked",
             sb.encodes_seen, sb.decode_bytes_seen, sb.results_checked);
    $display("decoded %0d words, flagged %0d overlong runs, %0d mismatches",
             sb.words_decoded, sb.overlong_runs, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
